>>> design/gapp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapp_pkg
// shared types, constants and helpers of the grid A* path planner
// ----------------------------------------------------------------------------
package gapp_pkg;

    localparam int GRID_SIDE = 8;
    localparam int COORD_W   = 3;
    localparam int CELL_W    = 2 * COORD_W;
    localparam int NODES     = GRID_SIDE * GRID_SIDE;
    localparam int COST_W    = 7;
    localparam int CNT_W     = 7;
    localparam int STEPS_W   = 6;
    localparam int PATH_MAX  = 63;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [COST_W-1:0]  cost_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        logic         mode;
        logic [2:0]   column_index;
        logic [7:0]   column_bits;
        logic [2:0]   start_x;
        logic [2:0]   start_y;
        logic [2:0]   goal_x;
        logic [2:0]   goal_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0]   point_x;
        logic [2:0]   point_y;
        logic         found;
        logic [6:0]   path_count;
        logic         last;
    } out_item_t;

    typedef struct packed {
        logic   root;
        cost_t  g;
        cost_t  f;
        cell_t  parent;
    } node_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_SEL, ST_SCAN_A, ST_SCAN_B, ST_SCAN_C, ST_PICK,
        ST_NB_A, ST_NB_B, ST_TR_A, ST_TR_B, ST_EM_A, ST_EM_B, ST_NOPATH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_INIT, OP_SEL, OP_SCAN_RD, OP_SCAN_NODE,
        OP_SCAN_CMP, OP_PICK, OP_NB_RD, OP_NB_UPD, OP_TR_RD, OP_TR_STEP,
        OP_EM_RD, OP_EM_OUT, OP_NOPATH
    } op_t;

    typedef struct packed {
        op_t   op;
        logic  s_ready;
    } cmd_t;

    typedef struct packed {
        logic is_plan;
        logic open_empty;
        logic scan_done;
        logic is_goal;
        logic nb_skip;
        logic dir_last;
        logic tr_stop;
        logic em_last;
        logic out_free;
    } status_t;

    function automatic coord_t adiff(input coord_t a, input coord_t b);
        return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
    endfunction

endpackage

>>> design/gapp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapp_ctrl
// sequencer of the planner: select, expand, trace back and emit
// ----------------------------------------------------------------------------
module gapp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  gapp_pkg::status_t sts,
    output gapp_pkg::cmd_t    cmd
);

    gapp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gapp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gapp_pkg::ST_IDLE: begin
                if (s_valid && sts.is_plan) state_next = gapp_pkg::ST_INIT;
            end
            gapp_pkg::ST_INIT:   state_next = gapp_pkg::ST_SEL;
            gapp_pkg::ST_SEL: begin
                state_next = sts.open_empty ? gapp_pkg::ST_NOPATH : gapp_pkg::ST_SCAN_A;
            end
            gapp_pkg::ST_SCAN_A: begin
                state_next = sts.scan_done ? gapp_pkg::ST_PICK : gapp_pkg::ST_SCAN_B;
            end
            gapp_pkg::ST_SCAN_B: state_next = gapp_pkg::ST_SCAN_C;
            gapp_pkg::ST_SCAN_C: state_next = gapp_pkg::ST_SCAN_A;
            gapp_pkg::ST_PICK: begin
                state_next = sts.is_goal ? gapp_pkg::ST_TR_A : gapp_pkg::ST_NB_A;
            end
            gapp_pkg::ST_NB_A: begin
                if (!sts.nb_skip) state_next = gapp_pkg::ST_NB_B;
                else if (sts.dir_last) state_next = gapp_pkg::ST_SEL;
                else state_next = gapp_pkg::ST_NB_A;
            end
            gapp_pkg::ST_NB_B: begin
                state_next = sts.dir_last ? gapp_pkg::ST_SEL : gapp_pkg::ST_NB_A;
            end
            gapp_pkg::ST_TR_A:   state_next = gapp_pkg::ST_TR_B;
            gapp_pkg::ST_TR_B: begin
                state_next = sts.tr_stop ? gapp_pkg::ST_EM_A : gapp_pkg::ST_TR_A;
            end
            gapp_pkg::ST_EM_A:   state_next = gapp_pkg::ST_EM_B;
            gapp_pkg::ST_EM_B: begin
                if (sts.out_free)
                    state_next = sts.em_last ? gapp_pkg::ST_IDLE : gapp_pkg::ST_EM_A;
            end
            gapp_pkg::ST_NOPATH: begin
                if (sts.out_free) state_next = gapp_pkg::ST_IDLE;
            end
            default: state_next = gapp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op      = gapp_pkg::OP_NONE;
        cmd.s_ready = 1'b0;
        case (state_reg)
            gapp_pkg::ST_IDLE: begin
                cmd.s_ready = 1'b1;
                if (s_valid) cmd.op = gapp_pkg::OP_ACCEPT;
            end
            gapp_pkg::ST_INIT:   cmd.op = gapp_pkg::OP_INIT;
            gapp_pkg::ST_SEL:    cmd.op = gapp_pkg::OP_SEL;
            gapp_pkg::ST_SCAN_A: cmd.op = gapp_pkg::OP_SCAN_RD;
            gapp_pkg::ST_SCAN_B: cmd.op = gapp_pkg::OP_SCAN_NODE;
            gapp_pkg::ST_SCAN_C: cmd.op = gapp_pkg::OP_SCAN_CMP;
            gapp_pkg::ST_PICK:   cmd.op = gapp_pkg::OP_PICK;
            gapp_pkg::ST_NB_A:   cmd.op = gapp_pkg::OP_NB_RD;
            gapp_pkg::ST_NB_B:   cmd.op = gapp_pkg::OP_NB_UPD;
            gapp_pkg::ST_TR_A:   cmd.op = gapp_pkg::OP_TR_RD;
            gapp_pkg::ST_TR_B:   cmd.op = gapp_pkg::OP_TR_STEP;
            gapp_pkg::ST_EM_A:   cmd.op = gapp_pkg::OP_EM_RD;
            gapp_pkg::ST_EM_B: begin
                if (sts.out_free) cmd.op = gapp_pkg::OP_EM_OUT;
            end
            gapp_pkg::ST_NOPATH: begin
                if (sts.out_free) cmd.op = gapp_pkg::OP_NOPATH;
            end
            default: cmd.op = gapp_pkg::OP_NONE;
        endcase
    end

endmodule

>>> design/gapp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapp_dp
// planner datapath: grid, node memory, open order list, path buffer, output
// ----------------------------------------------------------------------------
module gapp_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gapp_pkg::cmd_t              cmd,
    output gapp_pkg::status_t           sts,
    input  gapp_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output gapp_pkg::out_item_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gapp_pkg::STEPS_W-1:0] cfg_data
);

    localparam gapp_pkg::coord_t EDGE = gapp_pkg::coord_t'(gapp_pkg::GRID_SIDE - 1);

    // memories
    gapp_pkg::node_t node_mem [gapp_pkg::NODES];
    gapp_pkg::cell_t ord_mem  [gapp_pkg::NODES];
    gapp_pkg::cell_t path_mem [gapp_pkg::NODES];

    logic [7:0]                   occ_reg [gapp_pkg::GRID_SIDE];
    logic [gapp_pkg::STEPS_W-1:0] max_steps_reg;
    gapp_pkg::coord_t             sx_reg, sy_reg, gx_reg, gy_reg;
    logic [gapp_pkg::NODES-1:0]   in_open_reg, in_closed_reg;
    gapp_pkg::cnt_t               ord_cnt_reg, open_num_reg, k_reg, len_reg, em_idx_reg;
    gapp_pkg::node_t              node_rd_reg;
    gapp_pkg::cell_t              ord_rd_reg, path_rd_reg, scan_cell_reg;
    gapp_pkg::cell_t              best_cell_reg, cur_cell_reg, n_cell_reg, tr_cell_reg;
    gapp_pkg::cost_t              best_f_reg, best_g_reg, cur_g_reg, n_f_reg;
    logic                         best_ok_reg;
    logic [1:0]                   dir_reg;
    logic                         m_valid_reg;
    gapp_pkg::out_item_t          m_data_reg;

    gapp_pkg::coord_t cx, cy, nx, ny;
    logic             inb;
    gapp_pkg::cell_t  n_cell;
    gapp_pkg::cost_t  n_f, start_h;
    logic             out_free, tr_stop;

    // neighbour in +y, +x, -y, -x order
    always_comb begin
        cx  = cur_cell_reg[gapp_pkg::CELL_W-1:gapp_pkg::COORD_W];
        cy  = cur_cell_reg[gapp_pkg::COORD_W-1:0];
        nx  = cx;
        ny  = cy;
        inb = 1'b0;
        case (dir_reg)
            2'd0: begin ny = cy + 3'd1; inb = (cy != EDGE); end
            2'd1: begin nx = cx + 3'd1; inb = (cx != EDGE); end
            2'd2: begin ny = cy - 3'd1; inb = (cy != '0); end
            2'd3: begin nx = cx - 3'd1; inb = (cx != '0); end
            default: inb = 1'b0;
        endcase
        n_cell  = {nx, ny};
        n_f     = cur_g_reg + 7'd1
                + 7'({1'b0, gapp_pkg::adiff(nx, gx_reg)} + {1'b0, gapp_pkg::adiff(ny, gy_reg)});
        start_h = 7'({1'b0, gapp_pkg::adiff(s_data.start_x, s_data.goal_x)}
                   + {1'b0, gapp_pkg::adiff(s_data.start_y, s_data.goal_y)});
    end

    assign out_free = !m_valid_reg || m_ready;
    assign tr_stop  = node_rd_reg.root || (len_reg >= {1'b0, max_steps_reg})
                   || (len_reg == 7'(gapp_pkg::PATH_MAX));

    always_comb begin
        sts.is_plan    = s_data.mode;
        sts.open_empty = (open_num_reg == '0);
        sts.scan_done  = (k_reg == ord_cnt_reg);
        sts.is_goal    = (best_cell_reg == {gx_reg, gy_reg});
        sts.nb_skip    = !inb || occ_reg[nx][ny] || in_closed_reg[n_cell];
        sts.dir_last   = (dir_reg == 2'd3);
        sts.tr_stop    = tr_stop;
        sts.em_last    = (em_idx_reg == '0);
        sts.out_free   = out_free;
    end

    // node memory
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gapp_pkg::OP_INIT: begin
                node_mem[{sx_reg, sy_reg}] <= '{root: 1'b1, g: '0, f: n_f_reg, parent: '0};
            end
            gapp_pkg::OP_SCAN_NODE: node_rd_reg <= node_mem[ord_rd_reg];
            gapp_pkg::OP_NB_RD:     node_rd_reg <= node_mem[n_cell];
            gapp_pkg::OP_TR_RD:     node_rd_reg <= node_mem[tr_cell_reg];
            gapp_pkg::OP_NB_UPD: begin
                if (!in_open_reg[n_cell_reg] || (n_f_reg < node_rd_reg.f))
                    node_mem[n_cell_reg] <= '{root: 1'b0, g: cur_g_reg + 7'd1,
                                              f: n_f_reg, parent: cur_cell_reg};
            end
            default: ;
        endcase
    end

    // open order list and path buffer
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gapp_pkg::OP_INIT:    ord_mem[0] <= {sx_reg, sy_reg};
            gapp_pkg::OP_SCAN_RD: ord_rd_reg <= ord_mem[k_reg[gapp_pkg::CELL_W-1:0]];
            gapp_pkg::OP_NB_UPD: begin
                if (!in_open_reg[n_cell_reg])
                    ord_mem[ord_cnt_reg[gapp_pkg::CELL_W-1:0]] <= n_cell_reg;
            end
            gapp_pkg::OP_TR_STEP: begin
                path_mem[len_reg[gapp_pkg::CELL_W-1:0]] <=
                    tr_stop ? {sx_reg, sy_reg} : tr_cell_reg;
            end
            gapp_pkg::OP_EM_RD: path_rd_reg <= path_mem[em_idx_reg[gapp_pkg::CELL_W-1:0]];
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gapp_pkg::OP_ACCEPT: begin
                if (s_data.mode) begin
                    sx_reg  <= s_data.start_x;
                    sy_reg  <= s_data.start_y;
                    gx_reg  <= s_data.goal_x;
                    gy_reg  <= s_data.goal_y;
                    n_f_reg <= start_h;
                end
            end
            gapp_pkg::OP_SEL: begin
                k_reg       <= '0;
                best_ok_reg <= 1'b0;
            end
            gapp_pkg::OP_SCAN_NODE: scan_cell_reg <= ord_rd_reg;
            gapp_pkg::OP_SCAN_CMP: begin
                if (in_open_reg[scan_cell_reg] && (!best_ok_reg || node_rd_reg.f < best_f_reg)) begin
                    best_ok_reg   <= 1'b1;
                    best_cell_reg <= scan_cell_reg;
                    best_f_reg    <= node_rd_reg.f;
                    best_g_reg    <= node_rd_reg.g;
                end
                k_reg <= k_reg + 7'd1;
            end
            gapp_pkg::OP_PICK: begin
                cur_cell_reg <= best_cell_reg;
                cur_g_reg    <= best_g_reg;
                tr_cell_reg  <= best_cell_reg;
                dir_reg      <= '0;
                len_reg      <= '0;
            end
            gapp_pkg::OP_NB_RD: begin
                n_cell_reg <= n_cell;
                n_f_reg    <= n_f;
                if (sts.nb_skip) dir_reg <= dir_reg + 2'd1;
            end
            gapp_pkg::OP_NB_UPD: dir_reg <= dir_reg + 2'd1;
            gapp_pkg::OP_TR_STEP: begin
                len_reg <= len_reg + 7'd1;
                if (tr_stop) em_idx_reg <= len_reg;
                else tr_cell_reg <= node_rd_reg.parent;
            end
            gapp_pkg::OP_EM_OUT: em_idx_reg <= em_idx_reg - 7'd1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gapp_pkg::GRID_SIDE; i++) occ_reg[i] <= '0;
            max_steps_reg <= '1;
            in_open_reg   <= '0;
            in_closed_reg <= '0;
            ord_cnt_reg   <= '0;
            open_num_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) max_steps_reg <= cfg_data;
            if (cmd.op == gapp_pkg::OP_EM_OUT || cmd.op == gapp_pkg::OP_NOPATH)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
            case (cmd.op)
                gapp_pkg::OP_ACCEPT: begin
                    if (!s_data.mode) occ_reg[s_data.column_index] <= s_data.column_bits;
                end
                gapp_pkg::OP_INIT: begin
                    in_open_reg   <= {{(gapp_pkg::NODES-1){1'b0}}, 1'b1} << {sx_reg, sy_reg};
                    in_closed_reg <= '0;
                    ord_cnt_reg   <= 7'd1;
                    open_num_reg  <= 7'd1;
                end
                gapp_pkg::OP_PICK: begin
                    in_open_reg[best_cell_reg]   <= 1'b0;
                    in_closed_reg[best_cell_reg] <= 1'b1;
                    open_num_reg                 <= open_num_reg - 7'd1;
                end
                gapp_pkg::OP_NB_UPD: begin
                    if (!in_open_reg[n_cell_reg]) begin
                        in_open_reg[n_cell_reg] <= 1'b1;
                        ord_cnt_reg             <= ord_cnt_reg + 7'd1;
                        open_num_reg            <= open_num_reg + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            gapp_pkg::OP_EM_OUT: begin
                m_data_reg <= '{point_x: path_rd_reg[gapp_pkg::CELL_W-1:gapp_pkg::COORD_W],
                                point_y: path_rd_reg[gapp_pkg::COORD_W-1:0],
                                found: 1'b1, path_count: len_reg,
                                last: (em_idx_reg == '0)};
            end
            gapp_pkg::OP_NOPATH: begin
                m_data_reg <= '{point_x: '0, point_y: '0, found: 1'b0,
                                path_count: '0, last: 1'b1};
            end
            default: ;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

>>> design/grid_astar_path_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_path_planner
// A* search on an 8x8 occupancy grid, 4-connected, Manhattan heuristic
// ----------------------------------------------------------------------------
// channel  | ports                         | carries
// s_       | s_valid s_ready s_data        | column load or plan request
// m_       | m_valid m_ready m_data        | path points, start first
// cfg_     | cfg_valid cfg_ready cfg_data  | max_path_steps
//
// a column load is stored straight into the grid; a plan scans, for each
// expansion, every entry ever added to the open order list, serially through
// one port, and this serial scan sets the plan time
// path trace follows parent links from the goal, emission reads the path buffer
// one request at a time; m_ready low stalls emission, nothing is dropped
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module grid_astar_path_planner (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  gapp_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output gapp_pkg::out_item_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gapp_pkg::STEPS_W-1:0] cfg_data
);

    gapp_pkg::cmd_t    cmd;
    gapp_pkg::status_t sts;

    gapp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    gapp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    assign s_ready = cmd.s_ready;

endmodule

>>> design/gapp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapp_chk
// port-level checks of the path planner
// ----------------------------------------------------------------------------
module gapp_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input gapp_pkg::out_item_t          m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_nopath: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.last && (m_data.path_count == 7'd0))
        else $error("no-path result malformed");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> (m_data.path_count != 7'd0))
        else $error("found path with zero points");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("request taken in the middle of a path");

endmodule

bind grid_astar_path_planner gapp_chk u_gapp_chk (.*);
